// ----- hw/rtl/stxc_pkg.sv -----
// shared types and constants of the serial line discipline
package stxc_pkg;

    // request opcodes on the input channel
    localparam logic [1:0] OP_RX  = 2'd0;
    localparam logic [1:0] OP_TX  = 2'd1;
    localparam logic [1:0] OP_POP = 2'd2;

    // result kinds
    localparam logic [3:0] KIND_TX      = 4'd0;
    localparam logic [3:0] KIND_REFUSED = 4'd1;
    localparam logic [3:0] KIND_INTR    = 4'd2;
    localparam logic [3:0] KIND_QUIT    = 4'd3;
    localparam logic [3:0] KIND_STORED  = 4'd4;
    localparam logic [3:0] KIND_DROPPED = 4'd5;
    localparam logic [3:0] KIND_FLOW    = 4'd6;
    localparam logic [3:0] KIND_POPPED  = 4'd7;
    localparam logic [3:0] KIND_EMPTY   = 4'd8;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_START_CHAR = 3'd0;
    localparam logic [2:0] REG_STOP_CHAR  = 3'd1;
    localparam logic [2:0] REG_INTR_CHAR  = 3'd2;
    localparam logic [2:0] REG_QUIT_CHAR  = 3'd3;
    localparam logic [2:0] REG_RX_RAW     = 3'd4;
    localparam logic [2:0] REG_ANY_RESTART = 3'd5;
    localparam logic [2:0] REG_TX_RAW     = 3'd6;
    localparam logic [2:0] REG_CR_EXPAND  = 3'd7;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // character codes
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // line discipline settings
    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] stop_char;
        logic [7:0] intr_char;
        logic [7:0] quit_char;
        logic       rx_raw;
        logic       any_char_restarts;
        logic       tx_raw;
        logic       cr_expand;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        start_char:        8'd17,
        stop_char:         8'd19,
        intr_char:         8'd3,
        quit_char:         8'd28,
        rx_raw:            1'b0,
        any_char_restarts: 1'b0,
        tx_raw:            1'b0,
        cr_expand:         1'b1
    };

endpackage

// ----- hw/rtl/stxc_ram.sv -----
// generic single-write, single-read ram with registered read data
module stxc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/stxc_regs.sv -----
// apb register file holding the line discipline settings
module stxc_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stxc_pkg::ADDR_W-1:0] paddr,
    input  logic [stxc_pkg::DATA_W-1:0] pwdata,
    output logic [stxc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output stxc_pkg::cfg_t              cfg
);

    stxc_pkg::cfg_t cfg_reg;
    stxc_pkg::cfg_t cfg_next;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                stxc_pkg::REG_START_CHAR:  cfg_next.start_char        = pwdata[7:0];
                stxc_pkg::REG_STOP_CHAR:   cfg_next.stop_char         = pwdata[7:0];
                stxc_pkg::REG_INTR_CHAR:   cfg_next.intr_char         = pwdata[7:0];
                stxc_pkg::REG_QUIT_CHAR:   cfg_next.quit_char         = pwdata[7:0];
                stxc_pkg::REG_RX_RAW:      cfg_next.rx_raw            = pwdata[0];
                stxc_pkg::REG_ANY_RESTART: cfg_next.any_char_restarts = pwdata[0];
                stxc_pkg::REG_TX_RAW:      cfg_next.tx_raw            = pwdata[0];
                stxc_pkg::REG_CR_EXPAND:   cfg_next.cr_expand         = pwdata[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= stxc_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            stxc_pkg::REG_START_CHAR:  prdata = 32'(cfg_reg.start_char);
            stxc_pkg::REG_STOP_CHAR:   prdata = 32'(cfg_reg.stop_char);
            stxc_pkg::REG_INTR_CHAR:   prdata = 32'(cfg_reg.intr_char);
            stxc_pkg::REG_QUIT_CHAR:   prdata = 32'(cfg_reg.quit_char);
            stxc_pkg::REG_RX_RAW:      prdata = 32'(cfg_reg.rx_raw);
            stxc_pkg::REG_ANY_RESTART: prdata = 32'(cfg_reg.any_char_restarts);
            stxc_pkg::REG_TX_RAW:      prdata = 32'(cfg_reg.tx_raw);
            stxc_pkg::REG_CR_EXPAND:   prdata = 32'(cfg_reg.cr_expand);
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/serial_tx_xon_xoff_crlf.sv -----
// top level: serial line discipline with xon/xoff flow control and crlf expansion
//
// Input channel s_*: one request per item. s_tuser is the opcode (receive byte,
// transmit byte, pop buffered byte), s_tdata carries the byte and its receive
// error flags, s_tlast marks the final byte of a transmit request.
// Result channel m_*: m_tuser is the result kind, m_tlast marks the final result
// of a request, m_tdata carries the byte, write-done flag, ring fill count,
// block flag and sticky receive status after the request.
// Settings must be written over the apb port only while the block is idle;
// the block itself does not enforce this. A request taken is decoded into
// the middle stage (ram read issued there); its first result reaches m_*
// from the output register. One request per cycle while m_tready stays high; a line
// feed that expands to CR LF holds the middle stage, since it gives two results.
// The receive ring is a ram of RING_DEPTH bytes with one write and one read
// port; its fill count and pointers live in flip-flops, so no clearing pass.
// Reset clears the block flag, sticky status, pointers and fill count and
// loads the settings with their defaults; ring contents are left as they are.
// A stalled m_tready holds the output register, then the middle stage, then
// deasserts s_tready; no result is lost or repeated.
module serial_tx_xon_xoff_crlf #(
    parameter int RING_DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,  // data_byte[7:0], rx_flags[15:8]
    input  logic [1:0]                  s_tuser,  // op
    input  logic                        s_tlast,  // write_end
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_byte, write_done, buffered_count, blocked_now, rx_status, zero fill
    output logic [((18+$clog2(RING_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    output logic [3:0]                  m_tuser,  // kind
    output logic                        m_tlast,  // last
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stxc_pkg::ADDR_W-1:0] paddr,
    input  logic [stxc_pkg::DATA_W-1:0] pwdata,
    output logic [stxc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int PW = $clog2(RING_DEPTH);
    localparam int OW = ((18 + CW + 7) / 8) * 8;

    stxc_pkg::cfg_t cfg;

    // input field split
    logic [7:0] in_byte;
    logic [7:0] in_flags;
    logic       in_accept;

    // line state
    logic          blocked_reg, blocked_next;
    logic [7:0]    sticky_reg, sticky_next;
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // decode results
    logic       dec_valid;
    logic [3:0] dec_kind;
    logic [7:0] dec_byte;
    logic       dec_two;
    logic       dec_from_ram;
    logic       dec_done;
    logic       ram_we;
    logic       ram_re;
    logic [7:0] ram_rdata;

    // middle stage
    logic          p_valid_reg;
    logic          p_phase_reg;
    logic [3:0]    p_kind_reg;
    logic [7:0]    p_byte_reg;
    logic          p_two_reg;
    logic          p_from_ram_reg;
    logic          p_done_reg;
    logic [CW-1:0] p_cnt_reg;
    logic          p_blk_reg;
    logic [7:0]    p_sts_reg;
    logic          p_move;
    logic          p_finish;

    // output register
    logic          m_valid_reg;
    logic [3:0]    m_kind_reg;
    logic          m_last_reg;
    logic [OW-1:0] m_data_reg;
    logic [3:0]    o_kind;
    logic [7:0]    o_byte;
    logic          o_last;
    logic          o_done;

    assign in_byte   = s_tdata[7:0];
    assign in_flags  = s_tdata[15:8];
    assign in_accept = s_tvalid && s_tready;

    stxc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // request decode and state update
    always_comb begin
        blocked_next = blocked_reg;
        sticky_next  = sticky_reg;
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        cnt_next     = cnt_reg;
        dec_valid    = 1'b1;
        dec_kind     = stxc_pkg::KIND_DROPPED;
        dec_byte     = '0;
        dec_two      = 1'b0;
        dec_from_ram = 1'b0;
        dec_done     = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        unique case (s_tuser)
            stxc_pkg::OP_RX: begin
                sticky_next = sticky_reg | in_flags;
                if (!cfg.rx_raw) begin
                    if (cfg.any_char_restarts) begin
                        blocked_next = 1'b0;
                    end
                    priority if (in_byte == cfg.start_char) begin
                        blocked_next = 1'b0;
                        dec_kind     = stxc_pkg::KIND_FLOW;
                    end else if (in_byte == cfg.stop_char) begin
                        blocked_next = 1'b1;
                        dec_kind     = stxc_pkg::KIND_FLOW;
                    end else if (in_byte == cfg.intr_char) begin
                        dec_kind = stxc_pkg::KIND_INTR;
                    end else if (in_byte == cfg.quit_char) begin
                        dec_kind = stxc_pkg::KIND_QUIT;
                    end else if (cnt_reg < CW'(RING_DEPTH)) begin
                        ram_we    = in_accept;
                        wptr_next = (wptr_reg == PW'(RING_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                        dec_kind  = stxc_pkg::KIND_STORED;
                    end else begin
                        dec_kind = stxc_pkg::KIND_DROPPED;
                    end
                end
            end
            stxc_pkg::OP_TX: begin
                priority if (blocked_reg) begin
                    dec_kind = stxc_pkg::KIND_REFUSED;
                end else begin
                    dec_kind = stxc_pkg::KIND_TX;
                    dec_byte = in_byte;
                    dec_done = s_tlast;
                    dec_two  = (in_byte == stxc_pkg::CHAR_LF) && !cfg.tx_raw && cfg.cr_expand;
                end
            end
            stxc_pkg::OP_POP: begin
                if (cnt_reg == '0) begin
                    dec_kind = stxc_pkg::KIND_EMPTY;
                end else begin
                    ram_re       = in_accept;
                    rptr_next    = (rptr_reg == PW'(RING_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    dec_kind     = stxc_pkg::KIND_POPPED;
                    dec_from_ram = 1'b1;
                end
            end
            default: begin
                dec_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocked_reg <= 1'b0;
            sticky_reg  <= '0;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            cnt_reg     <= '0;
        end else if (in_accept) begin
            blocked_reg <= blocked_next;
            sticky_reg  <= sticky_next;
            wptr_reg    <= wptr_next;
            rptr_reg    <= rptr_next;
            cnt_reg     <= cnt_next;
        end
    end

    // receive ring
    stxc_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (in_byte),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    // middle stage handshake
    assign p_move   = p_valid_reg && (!m_valid_reg || m_tready);
    assign p_finish = p_move && (!p_two_reg || p_phase_reg);
    assign s_tready = !p_valid_reg || p_finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            p_phase_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                p_valid_reg <= dec_valid;
                p_phase_reg <= 1'b0;
            end else if (p_finish) begin
                p_valid_reg <= 1'b0;
                p_phase_reg <= 1'b0;
            end else if (p_move) begin
                p_phase_reg <= 1'b1;
            end
        end
    end

    // middle stage payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p_kind_reg     <= dec_kind;
            p_byte_reg     <= dec_byte;
            p_two_reg      <= dec_two;
            p_from_ram_reg <= dec_from_ram;
            p_done_reg     <= dec_done;
            p_cnt_reg      <= cnt_next;
            p_blk_reg      <= blocked_next;
            p_sts_reg      <= sticky_next;
        end
    end

    // result selection: carriage return first for an expanded line feed
    always_comb begin
        o_kind = p_kind_reg;
        o_byte = p_from_ram_reg ? ram_rdata : p_byte_reg;
        o_last = 1'b1;
        o_done = p_done_reg;
        if (p_two_reg && !p_phase_reg) begin
            o_byte = stxc_pkg::CHAR_CR;
            o_last = 1'b0;
            o_done = 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_move) begin
            m_kind_reg <= o_kind;
            m_last_reg <= o_last;
            m_data_reg <= OW'({p_sts_reg, p_blk_reg, p_cnt_reg, o_done, o_byte});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = m_data_reg;

    // fill count stays within the ring
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(RING_DEPTH))
        else $error("ring fill count above depth");

    // pointers meet only when the ring is empty or full
    a_ptr_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (wptr_reg == rptr_reg) == ((cnt_reg == '0) || (cnt_reg == CW'(RING_DEPTH))))
        else $error("ring pointers disagree with fill count");

    // second half of an expansion only exists for a held two-result item
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        p_phase_reg |-> (p_valid_reg && p_two_reg))
        else $error("expansion phase without a pending line feed");

    // a successful pop lowers the count by one
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser == stxc_pkg::OP_POP && cnt_reg != '0)
        |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("pop did not lower fill count");

    // a store is only written while the ring has room
    a_store: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (cnt_reg < CW'(RING_DEPTH)))
        else $error("ring written while full");

endmodule
